// ----- rtl/ffps_pkg.sv -----
// shared types, constants and helpers for the flow frame parser with statistics
package ffps_pkg;

    // field widths
    localparam int VAL_W    = 7;
    localparam int AVG_W    = 14;
    localparam int FCOUNT_W = 24;

    // value limits
    localparam logic [6:0] VALUE_MAX = 7'd99;
    localparam logic [6:0] VALUE_SAT = 7'd100;

    // characters
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_CLOSE   = 8'h7d;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;

    // parse phases: 0..10 walk the frame prefix
    localparam logic [3:0] PREFIX_LEN     = 4'd11;
    localparam logic [3:0] PH_START       = 4'd0;
    localparam logic [3:0] PH_FIRST_DIGIT = 4'd11;
    localparam logic [3:0] PH_DIGITS      = 4'd12;
    localparam logic [3:0] PH_AFTER_CLOSE = 4'd13;
    localparam logic [3:0] PH_ENDED       = 4'd14;

    // divider: quotient never exceeds 14 bits
    localparam int          DIV_STEPS = AVG_W;
    localparam logic [3:0]  STEP_LAST = 4'd0;
    localparam logic [3:0]  STEP_FIRST = 4'(DIV_STEPS - 1);

    // expected prefix byte at each position
    function automatic logic [7:0] frame_head(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h7b; // {
            4'd1:    ch = 8'h27; // '
            4'd2:    ch = 8'h63; // c
            4'd3:    ch = 8'h61; // a
            4'd4:    ch = 8'h75; // u
            4'd5:    ch = 8'h64; // d
            4'd6:    ch = 8'h61; // a
            4'd7:    ch = 8'h6c; // l
            4'd8:    ch = 8'h27; // '
            4'd9:    ch = 8'h3a; // :
            4'd10:   ch = 8'h20; // space
            default: ch = 8'hff;
        endcase
        return ch;
    endfunction

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_LOAD
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic take;      // input transfer this cycle
        logic prep_div;  // load numerator and shifted divisor
        logic div_step;  // one restoring division step
        logic load_out;  // move stats and quotient into the output register
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic frame_ok;  // current byte is a newline closing a good frame
        logic div_last;  // last division step in progress
        logic out_free;  // output register can take a new result
    } ctl_sts_t;

endpackage

// ----- rtl/flow_frame_parser_stats_unit.sv -----
// top level of the flow frame parser with running statistics
//
//  channel | signals                          | direction | transfer when
//  --------+----------------------------------+-----------+-----------------------
//  input   | in_valid, in_ready, rx_byte      | in        | in_valid && in_ready
//  output  | out_valid, out_ready, last_value, | out       | out_valid && out_ready
//          | max_value, min_value,            |           |
//          | average_hundredths, frame_count  |           |
//
//  an ordinary byte or a rejected line's newline leaves the unit ready for the next byte
//  a newline closing a good frame holds off the next byte until it has gone through
//  the statistics update, the numerator load, the one-bit-per-cycle restoring
//  divider that forms the average, and the load of the output register
//  the output register holds a result while the next bytes are parsed; the load
//  waits only if the previous result is still not taken
//  asynchronous active-low reset clears the parser, statistics and output valid
module flow_frame_parser_stats_unit
    import ffps_pkg::*;
#(
    parameter int LINE_BYTES = 100,
    parameter int COUNT_BITS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [VAL_W-1:0]    last_value,
    output logic [VAL_W-1:0]    max_value,
    output logic [VAL_W-1:0]    min_value,
    output logic [AVG_W-1:0]    average_hundredths,
    output logic [FCOUNT_W-1:0] frame_count
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // sequencer
    ffps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // parser, statistics and divider
    ffps_datapath #(
        .LINE_BYTES (LINE_BYTES),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .rx_byte            (rx_byte),
        .cmd                (cmd),
        .sts                (sts),
        .out_ready          (out_ready),
        .out_valid          (out_valid),
        .last_value         (last_value),
        .max_value          (max_value),
        .min_value          (min_value),
        .average_hundredths (average_hundredths),
        .frame_count        (frame_count)
    );

endmodule

// ----- rtl/ffps_ctrl.sv -----
// controller state machine for the flow frame parser
module ffps_ctrl
    import ffps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        xfer;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign xfer = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (xfer && sts.frame_ok)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.take     = 1'b0;
        cmd.prep_div = 1'b0;
        cmd.div_step = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            S_MUL:
            begin
                cmd.prep_div = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_LOAD:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/ffps_datapath.sv -----
// parser, statistics registers, average divider and output register
module ffps_datapath
    import ffps_pkg::*;
#(
    parameter int LINE_BYTES = 100,
    parameter int COUNT_BITS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          rx_byte,
    input  ctl_cmd_t            cmd,
    output ctl_sts_t            sts,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [VAL_W-1:0]    last_value,
    output logic [VAL_W-1:0]    max_value,
    output logic [VAL_W-1:0]    min_value,
    output logic [AVG_W-1:0]    average_hundredths,
    output logic [FCOUNT_W-1:0] frame_count
);

    localparam int LEN_W = $clog2(LINE_BYTES + 1);
    localparam int SUM_W = COUNT_BITS + 7;
    localparam int NUM_W = COUNT_BITS + 16;
    localparam int DSH_W = COUNT_BITS + 1 + (DIV_STEPS - 1);
    localparam logic [LEN_W-1:0]      LEN_LIMIT = LEN_W'(LINE_BYTES);
    localparam logic [LEN_W-1:0]      LEN_OK    = LEN_W'(LINE_BYTES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // line parser state
    logic [3:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             bad_reg, bad_next;
    logic [6:0]       dv_reg, dv_next;

    // statistics
    logic [VAL_W-1:0]      last_reg, max_reg, min_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [COUNT_BITS-1:0] count_reg;

    // divider
    logic [NUM_W-1:0] rem_reg;
    logic [DSH_W-1:0] dsh_reg;
    logic [AVG_W-1:0] quo_reg;
    logic [3:0]       step_reg;
    logic [NUM_W-1:0] dsh_ext;
    logic             rem_ge;

    // output register
    logic                out_valid_reg;
    logic [VAL_W-1:0]    o_last_reg, o_max_reg, o_min_reg;
    logic [AVG_W-1:0]    o_avg_reg;
    logic [FCOUNT_W-1:0] o_count_reg;
    logic [31:0]         count_wide;

    logic        is_digit;
    logic [10:0] dv_mul;
    logic        frame_ok;

    assign is_digit = (rx_byte >= CH_DIGIT0) && (rx_byte <= CH_DIGIT9);
    assign dv_mul   = {1'b0, dv_reg, 3'b000} + {3'b000, dv_reg, 1'b0}
                    + {7'd0, rx_byte[3:0]};

    // frame check on the closing newline
    assign frame_ok = (rx_byte == CH_NEWLINE) && !bad_reg
                    && ((phase_reg == PH_AFTER_CLOSE) || (phase_reg == PH_ENDED))
                    && (len_reg <= LEN_OK) && (dv_reg <= VALUE_MAX);

    // next line-parser state for one byte
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        bad_next   = bad_reg;
        dv_next    = dv_reg;
        if (rx_byte == CH_NEWLINE)
        begin
            phase_next = PH_START;
            len_next   = '0;
            bad_next   = 1'b0;
            dv_next    = '0;
        end
        else
        begin
            if (len_reg < LEN_LIMIT)
            begin
                len_next = len_reg + LEN_W'(1);
            end
            if ((phase_reg != PH_ENDED) && !bad_reg)
            begin
                if (rx_byte == CH_NUL)
                begin
                    if (phase_reg != PH_AFTER_CLOSE)
                    begin
                        bad_next = 1'b1;
                    end
                    phase_next = PH_ENDED;
                end
                else if (phase_reg < PREFIX_LEN)
                begin
                    if (rx_byte == frame_head(phase_reg))
                    begin
                        phase_next = phase_reg + 4'd1;
                    end
                    else
                    begin
                        bad_next = 1'b1;
                    end
                end
                else if ((phase_reg == PH_FIRST_DIGIT) || (phase_reg == PH_DIGITS))
                begin
                    if (is_digit)
                    begin
                        dv_next    = (dv_mul > 11'(VALUE_MAX)) ? VALUE_SAT : dv_mul[6:0];
                        phase_next = PH_DIGITS;
                    end
                    else if ((rx_byte == CH_CLOSE) && (phase_reg == PH_DIGITS))
                    begin
                        phase_next = PH_AFTER_CLOSE;
                    end
                    else
                    begin
                        bad_next = 1'b1;
                    end
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
        end
    end

    // parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            len_reg   <= '0;
            bad_reg   <= 1'b0;
            dv_reg    <= '0;
        end
        else if (cmd.take)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            bad_reg   <= bad_next;
            dv_reg    <= dv_next;
        end
    end

    // statistics update on a good frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= '0;
            max_reg   <= '0;
            min_reg   <= VALUE_SAT;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.take && frame_ok)
        begin
            last_reg <= dv_reg;
            if (dv_reg > max_reg)
            begin
                max_reg <= dv_reg;
            end
            if (dv_reg < min_reg)
            begin
                min_reg <= dv_reg;
            end
            if (count_reg != COUNT_MAX)
            begin
                sum_reg   <= sum_reg + SUM_W'(dv_reg);
                count_reg <= count_reg + COUNT_BITS'(1);
            end
        end
    end

    // restoring divider: (200*sum + count) / (2*count), one quotient bit a cycle
    assign dsh_ext = NUM_W'(dsh_reg);
    assign rem_ge  = rem_reg >= dsh_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.prep_div)
        begin
            rem_reg  <= (NUM_W'(sum_reg) << 7) + (NUM_W'(sum_reg) << 6)
                      + (NUM_W'(sum_reg) << 3) + NUM_W'(count_reg);
            dsh_reg  <= {count_reg, 1'b0, {(DIV_STEPS - 1){1'b0}}};
            quo_reg  <= '0;
            step_reg <= STEP_FIRST;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - dsh_ext;
            end
            dsh_reg  <= dsh_reg >> 1;
            quo_reg  <= {quo_reg[AVG_W-2:0], rem_ge};
            step_reg <= step_reg - 4'd1;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign count_wide = 32'(count_reg);

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            o_last_reg  <= last_reg;
            o_max_reg   <= max_reg;
            o_min_reg   <= min_reg;
            o_avg_reg   <= quo_reg;
            o_count_reg <= count_wide[FCOUNT_W-1:0];
        end
    end

    // status to controller
    assign sts.frame_ok = frame_ok;
    assign sts.div_last = (step_reg == STEP_LAST);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid          = out_valid_reg;
    assign last_value         = o_last_reg;
    assign max_value          = o_max_reg;
    assign min_value          = o_min_reg;
    assign average_hundredths = o_avg_reg;
    assign frame_count        = o_count_reg;

`ifndef ASSERT_OFF
    // digit accumulator never passes its saturation value
    a_dv_range: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg <= VALUE_SAT)
        else $error("digit value out of range");

    // line length saturates at the line limit
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_LIMIT)
        else $error("line length out of range");

    // a delivered average is never above the largest possible value
    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (o_avg_reg <= AVG_W'(9900)))
        else $error("average out of range");

    // any delivered result has min not above max
    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (o_min_reg <= o_max_reg))
        else $error("min above max");

    // a good frame always leaves a nonzero count for the divider
    a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.prep_div |-> (count_reg != '0))
        else $error("division by zero count");
`endif

endmodule
